FILE: rtl/cqc_pkg.sv
// Shared types, constants and helpers for the completion queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package cqc_pkg;

  // Ring depth and the widths that follow from it.
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int SUM_W       = PTR_W + 2;

  // Packed widths of the stream words.
  localparam int IN_W  = 104;
  localparam int OUT_W = 176;
  localparam int OP_W  = 3;

  localparam logic [63:0] DROP_MAX = '1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_CANCEL  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_CONSUME = 3'd4;

  // Enqueue status codes.
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  // Outcome codes.
  localparam logic [1:0] OC_READY  = 2'd0;
  localparam logic [1:0] OC_FAILED = 2'd1;

  typedef struct packed {
    logic [31:0]        token;
    logic [31:0]        generation;
    logic [1:0]         outcome;
    logic signed [31:0] failure;
  } cqc_entry_t;

  // One result word, first field in the highest bits.
  typedef struct packed {
    logic [CNT_W-1:0]   occupancy;
    logic [63:0]        overflow_count;
    logic [CNT_W-1:0]   removed_count;
    logic signed [31:0] failure_out;
    logic [1:0]         outcome_out;
    logic [31:0]        generation_out;
    logic [31:0]        token_out;
    logic               took;
    logic               notify_request;
    logic [1:0]         enqueue_status;
  } cqc_res_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cqc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walking;
    logic last;
  } cqc_sts_t;

  // Ring slot that lies off entries past the head.
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

FILE: rtl/cqc_ctrl.sv
// Sequencing state machine of the completion queue.
// Depends on cqc_pkg; drives the datapath through cqc_cmd_t.
module cqc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  cqc_pkg::cqc_sts_t sts,
  output cqc_pkg::cqc_cmd_t cmd
);
  import cqc_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.walking && !sts.last) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          // The final walk step and the commit share one cycle.
          cmd.step      = sts.walking;
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/cqc_dp.sv
// Datapath of the completion queue: event memory, ring pointers, counters
// and the result register. Depends on cqc_pkg; steered by cqc_ctrl.
module cqc_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [cqc_pkg::IN_W-1:0] in_tdata,
  input  logic [cqc_pkg::OP_W-1:0] in_tuser,
  input  cqc_pkg::cqc_cmd_t        cmd,
  output cqc_pkg::cqc_sts_t        sts,
  output cqc_pkg::cqc_res_t        res
);
  import cqc_pkg::*;

  // Event memory: one write and one registered read per cycle.
  cqc_entry_t mem [QUEUE_DEPTH];
  cqc_entry_t rd_data_r;

  logic [OP_W-1:0]  op_r;
  cqc_entry_t       ev_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [63:0]      drop_r, drop_nxt;
  logic             notify_r, notify_nxt;
  logic [CNT_W-1:0] idx_r, kept_r;
  cqc_res_t         res_r, res_nxt;

  logic             ev_ok, is_full, keep, rd_en, wr_en;
  logic [PTR_W-1:0] rd_addr, wr_addr;
  cqc_entry_t       wr_data;
  logic [CNT_W-1:0] kept_fin;

  assign ev_ok = (ev_r.token != '0) && (ev_r.generation != '0) &&
                 (((ev_r.outcome == OC_READY) && (ev_r.failure == '0)) ||
                  ((ev_r.outcome == OC_FAILED) && ev_r.failure[31]));
  assign is_full = (fill_r >= CNT_W'(QUEUE_DEPTH));

  // Cancel walk: the entry at idx_r is in rd_data_r and survives unless its
  // generation matches.
  assign keep     = (rd_data_r.generation != ev_r.generation);
  assign kept_fin = kept_r + CNT_W'(keep);

  assign sts.walking = (op_r == OP_CANCEL) && (ev_r.generation != '0) && (fill_r != '0);
  assign sts.last    = (idx_r == fill_r - CNT_W'(1));

  assign rd_en   = cmd.load || cmd.step;
  assign rd_addr = cmd.load ? head_r : slot_add(head_r, idx_r + CNT_W'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_add(head_r, kept_r);
    wr_data = rd_data_r;
    if (op_r == OP_ENQUEUE) begin
      wr_en   = cmd.commit && ev_ok && !is_full;
      wr_addr = slot_add(head_r, fill_r);
      wr_data = ev_r;
    end else if (cmd.step && keep) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    drop_nxt   = drop_r;
    notify_nxt = notify_r;
    res_nxt    = '0;
    case (op_r)
      OP_ENQUEUE: begin
        if (!ev_ok) begin
          res_nxt.enqueue_status = ST_INVALID;
        end else begin
          // The ring is nonempty after any valid enqueue, so only the
          // pending flag decides the notification.
          res_nxt.notify_request = !notify_r;
          notify_nxt             = 1'b1;
          if (is_full) begin
            res_nxt.enqueue_status = ST_FULL;
            if (drop_r != DROP_MAX) begin
              drop_nxt = drop_r + 64'd1;
            end
          end else begin
            res_nxt.enqueue_status = ST_ACCEPTED;
            fill_nxt               = fill_r + CNT_W'(1);
          end
        end
      end
      OP_POP: begin
        if (fill_r != '0) begin
          res_nxt.took           = 1'b1;
          res_nxt.token_out      = rd_data_r.token;
          res_nxt.generation_out = rd_data_r.generation;
          res_nxt.outcome_out    = rd_data_r.outcome;
          res_nxt.failure_out    = rd_data_r.failure;
          fill_nxt               = fill_r - CNT_W'(1);
          head_nxt               = (fill_r == CNT_W'(1)) ? '0 : slot_add(head_r, CNT_W'(1));
        end
      end
      OP_CANCEL: begin
        if (sts.walking) begin
          fill_nxt              = kept_fin;
          res_nxt.removed_count = fill_r - kept_fin;
          if (kept_fin == '0) begin
            head_nxt = '0;
          end
        end
      end
      OP_CLEAR: begin
        res_nxt.removed_count = fill_r;
        fill_nxt              = '0;
        head_nxt              = '0;
      end
      OP_CONSUME: begin
        res_nxt.took = notify_r;
        notify_nxt   = 1'b0;
      end
      default: ;
    endcase
    res_nxt.overflow_count = drop_nxt;
    res_nxt.occupancy      = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r            <= in_tuser;
      ev_r.token      <= in_tdata[31:0];
      ev_r.generation <= in_tdata[63:32];
      ev_r.outcome    <= in_tdata[65:64];
      ev_r.failure    <= in_tdata[97:66];
      idx_r           <= '0;
      kept_r          <= '0;
    end else if (cmd.step) begin
      idx_r  <= idx_r + CNT_W'(1);
      kept_r <= kept_fin;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      fill_r   <= '0;
      drop_r   <= '0;
      notify_r <= 1'b0;
    end else if (cmd.commit) begin
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      drop_r   <= drop_nxt;
      notify_r <= notify_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/completion_queue_with_cancel.sv
// Completion queue with generation cancel: a 16-entry ring of completion
// events (token, generation, outcome, failure code) driven by one command
// word per input transfer, answering each with exactly one result word.
// Enqueue, pop, clear, consume and unused opcodes first capture the word
// and read the head slot of the event memory, then update the ring and
// load the output register once that register is free. Cancel walks the
// ring one entry per cycle through the single memory read port, compacting
// survivors in place through the write port, and commits with its last
// entry once the output register is free; with a zero generation or an
// empty ring it takes the same path as the others.
// The block works on one command at a time, and a new command is accepted
// while the previous result still waits in the output register.
// Depends on cqc_pkg, cqc_ctrl and cqc_dp.
module completion_queue_with_cancel (
  input  logic                      clk,
  input  logic                      rst_n,
  // Command word.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // token_in[31:0], generation_in[63:32], outcome_in[65:64],
  // failure_in[97:66], zero fill [103:98].
  input  logic [cqc_pkg::IN_W-1:0]  in_tdata,
  // opcode[2:0].
  input  logic [cqc_pkg::OP_W-1:0]  in_tuser,
  // Result word.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // enqueue_status[1:0], notify_request[2], took[3], token_out[35:4],
  // generation_out[67:36], outcome_out[69:68], failure_out[101:70],
  // removed_count[106:102], overflow_count[170:107], occupancy[175:171].
  output logic [cqc_pkg::OUT_W-1:0] out_tdata
);
  import cqc_pkg::*;

  cqc_cmd_t cmd;
  cqc_sts_t sts;
  cqc_res_t res;

  // The controller only sequences; every ring pointer and queue counter update happens
  // in the datapath on a commit, which also loads the result register.
  cqc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cqc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .res      (res)
  );

  assign out_tdata = res;

  // Accepting a command always makes the block busy, so commands are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command accepted while another is in progress");

  // A dropped enqueue can only happen on a full ring.
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res.enqueue_status == ST_FULL)) |->
      (res.occupancy == CNT_W'(QUEUE_DEPTH)))
    else $error("full status with free slots");

  // Removed plus remaining entries never exceed the ring depth.
  a_removed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((SUM_W'(res.removed_count) + SUM_W'(res.occupancy)) <= SUM_W'(QUEUE_DEPTH)))
    else $error("removed and remaining entries exceed the ring depth");

  // Walking only runs while a cancel holds the machine busy.
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!in_tready && sts.walking))
    else $error("cancel walk step outside a cancel");

endmodule

FILE: tb/completion_queue_with_cancel_tb.sv
// Self-checking testbench for the completion queue with generation cancel.
// Drives command words, predicts every result word in-line, and checks them in order.
// Depends on cqc_pkg and completion_queue_with_cancel.
module completion_queue_with_cancel_tb;
  import cqc_pkg::*;

  // A run of this many cycles without any accepted word on either side ends the run.
  localparam int STALL_LIMIT = 2000;
  // The slowest command is a cancel over a full ring; this tail is ample for it.
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1400;
  // Generations are mostly drawn from a small pool so that cancels find matches.
  localparam int GEN_POOL = 4;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [31:0]        token;
    logic [31:0]        generation;
    logic [1:0]         outcome;
    logic signed [31:0] failure;
    bit                 drain_first;  // hold this word until every result has arrived
  } queue_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  completion_queue_with_cancel DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  queue_cmd_t pending_cmds[$];
  queue_cmd_t cur_cmd;
  cqc_res_t   expected_words[$];
  int         words_sent = 0;
  int         mismatches = 0;
  int         random_items = 0;

  // Predicted ring contents and control state.
  logic [31:0]        ring_token [QUEUE_DEPTH];
  logic [31:0]        ring_gen   [QUEUE_DEPTH];
  logic [1:0]         ring_oc    [QUEUE_DEPTH];
  logic signed [31:0] ring_code  [QUEUE_DEPTH];
  int                 head_slot = 0;
  int                 fill_level = 0;
  logic [63:0]        dropped_total = '0;
  bit                 notify_pending = 1'b0;

  // Run statistics for the closing summary.
  int n_accepted = 0;
  int n_dropped = 0;
  int n_invalid = 0;
  int n_delivered = 0;
  int n_removed = 0;
  int n_full_seen = 0;

  // Neither side stalls at random while the count of sent words is in this range, giving one long busy stretch.
  wire calm = (words_sent >= 500) && (words_sent < 800);

  function automatic int slot_at(input int offset);
    return (head_slot + offset) % QUEUE_DEPTH;
  endfunction

  // The notification flag is one-shot: only the first enqueue that finds it clear raises it.
  function automatic logic raise_notify();
    if (fill_level == 0 || notify_pending) begin
      return 1'b0;
    end
    notify_pending = 1'b1;
    return 1'b1;
  endfunction

  // Applies one command to the predicted ring and returns the result word it must produce.
  function automatic cqc_res_t ring_predict(input queue_cmd_t c);
    cqc_res_t r;
    int s;
    int prev;
    int kept;
    int rd;
    int wr;
    r = '0;
    case (c.op)
      OP_ENQUEUE: begin
        // An event needs a nonzero token and generation, and a ready outcome carries code
        // zero while a failed one carries a negative code.
        if (c.token == 0 || c.generation == 0 ||
            !((c.outcome == OC_READY && c.failure == 0) ||
              (c.outcome == OC_FAILED && c.failure[31]))) begin
          r.enqueue_status = ST_INVALID;
          n_invalid++;
        end else if (fill_level >= QUEUE_DEPTH) begin
          // The drop counter saturates rather than wrapping.
          if (dropped_total != DROP_MAX) begin
            dropped_total++;
          end
          r.enqueue_status = ST_FULL;
          r.notify_request = raise_notify();
          n_dropped++;
        end else begin
          s = slot_at(fill_level);
          ring_token[s] = c.token;
          ring_gen[s]   = c.generation;
          ring_oc[s]    = c.outcome;
          ring_code[s]  = c.failure;
          fill_level++;
          r.enqueue_status = ST_ACCEPTED;
          r.notify_request = raise_notify();
          n_accepted++;
          if (fill_level == QUEUE_DEPTH) begin
            n_full_seen++;
          end
        end
      end
      OP_POP: begin
        if (fill_level != 0) begin
          s = head_slot;
          r.took           = 1'b1;
          r.token_out      = ring_token[s];
          r.generation_out = ring_gen[s];
          r.outcome_out    = ring_oc[s];
          r.failure_out    = ring_code[s];
          head_slot = (s + 1) % QUEUE_DEPTH;
          fill_level--;
          // The head goes back to slot zero whenever the ring empties.
          if (fill_level == 0) begin
            head_slot = 0;
          end
          n_delivered++;
        end
      end
      OP_CANCEL: begin
        if (c.generation != 0 && fill_level != 0) begin
          // Survivors slide toward the head in their original order.
          prev = fill_level;
          kept = 0;
          for (int i = 0; i < prev; i++) begin
            rd = slot_at(i);
            if (ring_gen[rd] != c.generation) begin
              wr = slot_at(kept);
              ring_token[wr] = ring_token[rd];
              ring_gen[wr]   = ring_gen[rd];
              ring_oc[wr]    = ring_oc[rd];
              ring_code[wr]  = ring_code[rd];
              kept++;
            end
          end
          fill_level = kept;
          if (fill_level == 0) begin
            head_slot = 0;
          end
          r.removed_count = CNT_W'(prev - kept);
          n_removed += prev - kept;
        end
      end
      OP_CLEAR: begin
        r.removed_count = CNT_W'(fill_level);
        n_removed += fill_level;
        head_slot = 0;
        fill_level = 0;
      end
      OP_CONSUME: begin
        if (notify_pending) begin
          notify_pending = 1'b0;
          r.took = 1'b1;
        end
      end
      default: begin
        // Unused opcodes change nothing and report only the counters below.
      end
    endcase
    r.overflow_count = dropped_total;
    r.occupancy      = CNT_W'(fill_level);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [31:0] tok,
                          input logic [31:0] gen, input logic [1:0] oc,
                          input logic [31:0] code, input bit drain);
    queue_cmd_t c;
    c.op          = op;
    c.token       = tok;
    c.generation  = gen;
    c.outcome     = oc;
    c.failure     = code;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [31:0] nonzero_word();
    logic [31:0] w;
    w = $urandom;
    return (w == 0) ? 32'd1 : w;
  endfunction

  function automatic logic [31:0] pick_generation();
    if ($urandom_range(0, 99) < 80) begin
      return 32'($urandom_range(1, GEN_POOL));
    end
    return nonzero_word();
  endfunction

  // A well-formed event: ready with code zero, or failed with a negative code.
  task automatic push_valid_event(input logic [31:0] gen, input bit drain);
    if ($urandom_range(0, 1) == 0) begin
      push_cmd(OP_ENQUEUE, nonzero_word(), gen, OC_READY, 32'd0, drain);
    end else begin
      push_cmd(OP_ENQUEUE, nonzero_word(), gen, OC_FAILED, $urandom | 32'h8000_0000, drain);
    end
  endtask

  // Driver: presents the oldest pending command word and holds it until it is accepted.
  // Each accepted word is run through the predictor at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_words.push_back(ring_predict(cur_cmd));
        words_sent <= words_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        // A word marked drain_first waits until the last result has left the block.
        // Checking out_tvalid keeps this decision free of the monitor's update order.
        if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 12) &&
            (!pending_cmds[0].drain_first ||
             (expected_words.size() == 0 && !out_tvalid))) begin
          cur_cmd = pending_cmds.pop_front();
          in_tuser  <= cur_cmd.op;
          in_tdata  <= {6'b0, cur_cmd.failure, cur_cmd.outcome, cur_cmd.generation,
                        cur_cmd.token};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result words under a randomly stalling ready and checks each one
  // against the oldest prediction, field by field.
  always @(posedge clk) begin
    cqc_res_t want;
    cqc_res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_words.size() == 0) begin
          $error("result word 0x%0h arrived with no command outstanding", out_tdata);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          compare_field("enqueue_status", want.enqueue_status, got.enqueue_status);
          compare_field("notify_request", want.notify_request, got.notify_request);
          compare_field("took", want.took, got.took);
          compare_field("token_out", want.token_out, got.token_out);
          compare_field("generation_out", want.generation_out, got.generation_out);
          compare_field("outcome_out", want.outcome_out, got.outcome_out);
          compare_field("failure_out", want.failure_out, got.failure_out);
          compare_field("removed_count", want.removed_count, got.removed_count);
          compare_field("overflow_count", want.overflow_count, got.overflow_count);
          compare_field("occupancy", want.occupancy, got.occupancy);
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  // Watchdog: ends the run if neither channel moves a word for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    do begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end while (stall_cycles < STALL_LIMIT);
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int kind;
    int n;
    int pick;
    logic [31:0] g;
    bit drain;

    // Directed part: empty-ring corner cases first.
    push_cmd(OP_POP, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_CONSUME, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_CANCEL, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_CANCEL, 32'd0, 32'd5, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_CLEAR, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    for (int k = OP_CONSUME + 1; k < (1 << OP_W); k++) begin
      push_cmd(OP_W'(k), '1, '1, 2'd3, '1, 1'b0);
    end
    // Every way an enqueue can be rejected.
    push_cmd(OP_ENQUEUE, 32'd0, 32'd1, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd1, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd1, 32'd1, 2'd2, 32'd0, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd1, 32'd1, 2'd3, 32'h8000_0000, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd1, 32'd1, OC_READY, 32'd1, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd1, 32'd1, OC_FAILED, 32'd0, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd1, 32'd1, OC_FAILED, 32'h7FFF_FFFF, 1'b0);
    // Accepted events at the field extremes; the first raises the notification.
    push_cmd(OP_ENQUEUE, '1, '1, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd1, 32'd1, OC_FAILED, 32'h8000_0000, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd2, 32'd2, OC_FAILED, '1, 1'b0);
    push_cmd(OP_CONSUME, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_CONSUME, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    // Cancel from the middle, then drain to empty so the head returns to slot zero.
    push_cmd(OP_CANCEL, 32'd0, 32'd1, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_POP, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_POP, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_POP, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_ENQUEUE, 32'd3, 32'd3, OC_READY, 32'd0, 1'b0);
    push_cmd(OP_CLEAR, 32'd0, 32'd0, OC_READY, 32'd0, 1'b0);

    // Random part: mostly well-formed sequences, with some noise. The first word waits
    // for the directed part to drain completely.
    drain = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 34) begin
        // Enqueue bursts long enough to fill the ring and run into drops.
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          push_valid_event(pick_generation(), drain);
          drain = 1'b0;
        end
        random_items += n;
      end else if (kind < 56) begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          push_cmd(OP_POP, $urandom, $urandom, 2'($urandom), $urandom, drain);
          drain = 1'b0;
        end
        random_items += n;
      end else if (kind < 68) begin
        pick = $urandom_range(0, 99);
        g = (pick < 75) ? 32'($urandom_range(1, GEN_POOL)) :
            (pick < 90) ? nonzero_word() : 32'd0;
        push_cmd(OP_CANCEL, $urandom, g, 2'($urandom), $urandom, drain);
        random_items++;
      end else if (kind < 76) begin
        push_cmd(OP_CONSUME, $urandom, $urandom, 2'($urandom), $urandom, drain);
        random_items++;
      end else if (kind < 80) begin
        push_cmd(OP_CLEAR, $urandom, $urandom, 2'($urandom), $urandom, drain);
        random_items++;
      end else if (kind < 90) begin
        // Interleaved enqueue and pop walks the head around the ring.
        n = $urandom_range(2, 12);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 2) != 0) begin
            push_valid_event(pick_generation(), drain);
          end else begin
            push_cmd(OP_POP, 32'd0, 32'd0, OC_READY, 32'd0, drain);
          end
          drain = 1'b0;
        end
        random_items += n;
      end else begin
        // Noise: any opcode with loosely random fields; enqueues among them are mostly rejected.
        push_cmd(OP_W'($urandom_range(0, (1 << OP_W) - 1)),
                 ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                 ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                 2'($urandom_range(0, 3)),
                 ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom, drain);
      end
      drain = drain || ($urandom_range(0, 99) < 2);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every command has been sent and answered, then let the block settle.
    while (pending_cmds.size() != 0 || in_tvalid || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_words.size() != 0) begin
      $error("%0d predicted result words never arrived", expected_words.size());
      mismatches++;
    end
    $display("%0d command words: %0d enqueued, %0d dropped full, %0d rejected, %0d popped,",
             words_sent, n_accepted, n_dropped, n_invalid, n_delivered);
    $display("%0d removed by cancel or clear, ring filled %0d times, %0d mismatches",
             n_removed, n_full_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
